/* src/sfd_pkg.sv */
// Shared types and constants for the SLIP frame decoder.
package sfd_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int LEN_FIELD_BITS = 16;

    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [31:0] LEN_FIELD_MAX = 32'((64'd1 << LEN_FIELD_BITS) - 64'd1);

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_DROP = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                     kind;
        logic [7:0]                data_byte;
        logic [LEN_FIELD_BITS-1:0] packet_length;
    } result_t;

    typedef struct packed {
        logic                   in_packet;
        logic                   after_escape;
        logic                   dropping;
        logic [LENGTH_BITS-1:0] byte_count;
    } dec_state_t;

endpackage

/* src/sfd_in_reg.sv */
// Input register stage holding one received byte.
module sfd_in_reg
    import sfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] rx_byte,
    output logic       byte_stall,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    assign byte_stall = valid_reg && !advance;
    assign load       = byte_valid && !byte_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance || !valid_reg)
        begin
            valid_next = byte_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

/* src/sfd_decode.sv */
// Framing state and per-byte decode logic.
module sfd_decode
    import sfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    output result_t    res
);

    dec_state_t state_reg;
    dec_state_t state_next;
    logic [31:0] count_ext;

    assign count_ext = 32'(state_reg.byte_count);

    always_comb
    begin
        state_next = state_reg;
        res_valid  = 1'b0;
        res        = '{kind: KIND_DATA, data_byte: 8'd0, packet_length: '0};

        if (state_reg.after_escape && state_reg.in_packet)
        begin
            state_next.after_escape = 1'b0;
            if (rx_byte == SLIP_ESC_ESC || rx_byte == SLIP_ESC_END)
            begin
                if (!state_reg.dropping)
                begin
                    res_valid     = 1'b1;
                    res.data_byte = (rx_byte == SLIP_ESC_ESC) ? SLIP_ESC : SLIP_END;
                    if (state_reg.byte_count != COUNT_MAX)
                    begin
                        state_next.byte_count = state_reg.byte_count + 1'b1;
                    end
                end
            end
            else
            begin
                // bad escape: consume the byte, report drop once
                state_next.byte_count = '0;
                state_next.dropping   = 1'b1;
                if (!state_reg.dropping)
                begin
                    res_valid = 1'b1;
                    res.kind  = KIND_DROP;
                end
            end
        end
        else if (rx_byte == SLIP_END)
        begin
            if (state_reg.in_packet)
            begin
                if (!state_reg.dropping && state_reg.byte_count != '0)
                begin
                    res_valid = 1'b1;
                    res.kind  = KIND_GOOD;
                    res.packet_length = (count_ext > LEN_FIELD_MAX) ?
                        LEN_FIELD_MAX[LEN_FIELD_BITS-1:0] : count_ext[LEN_FIELD_BITS-1:0];
                end
            end
            state_next.in_packet    = !state_reg.in_packet;
            state_next.dropping     = 1'b0;
            state_next.after_escape = 1'b0;
            state_next.byte_count   = '0;
        end
        else if (rx_byte == SLIP_ESC)
        begin
            if (state_reg.in_packet)
            begin
                state_next.after_escape = 1'b1;
            end
        end
        else if (state_reg.in_packet && !state_reg.dropping)
        begin
            res_valid     = 1'b1;
            res.data_byte = rx_byte;
            if (state_reg.byte_count != COUNT_MAX)
            begin
                state_next.byte_count = state_reg.byte_count + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/sfd_out_reg.sv */
// Result register driving the output channel.
module sfd_out_reg
    import sfd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load_en,
    input  logic                      res_valid,
    input  result_t                   res,
    output logic                      out_ready,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [1:0]                kind,
    output logic [7:0]                data_byte,
    output logic [LEN_FIELD_BITS-1:0] packet_length
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_ready = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ready)
        begin
            valid_next = load_en && res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && load_en && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign result_valid  = valid_reg;
    assign kind          = res_reg.kind;
    assign data_byte     = res_reg.data_byte;
    assign packet_length = res_reg.packet_length;

endmodule

/* src/slip_frame_decoder.sv */
// Top level of the SLIP frame decoder.
//
// Input channel: one raw SLIP byte per transfer on rx_byte, byte_valid/byte_stall.
// Output channel: zero or one result per byte on kind, data_byte, packet_length,
// result_valid/result_stall. kind 0 is a decoded data byte, 1 a good packet end
// with its length, 2 a dropped packet (reported once per packet).
// Each byte is registered in the input register and decoded, and its result is
// registered in the result register, which holds it until it is taken.
// Throughput: one byte per cycle while the output is not stalled, set by the
// single decode step between the two registers; bytes that give no result
// (END opening a packet, ESC, idle bytes) still take a decode step.
// When the receiver stalls, the result register holds; the input register
// keeps taking bytes until it too is full, then byte_stall rises.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// framing state to outside a packet with a zero byte count.
// Byte counts saturate at 2^LENGTH_BITS - 1; packet_length at 65535.
module slip_frame_decoder
    import sfd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      byte_valid,
    output logic                      byte_stall,
    input  logic [7:0]                rx_byte,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [1:0]                kind,
    output logic [7:0]                data_byte,
    output logic [LEN_FIELD_BITS-1:0] packet_length
);

    logic       held_valid;
    logic [7:0] held_byte;
    logic       out_ready;
    logic       step;
    logic       res_valid;
    result_t    res;

    assign step = held_valid && out_ready;

    sfd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte),
        .byte_stall (byte_stall),
        .advance    (out_ready),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    sfd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (held_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    sfd_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load_en       (step),
        .res_valid     (res_valid),
        .res           (res),
        .out_ready     (out_ready),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .kind          (kind),
        .data_byte     (data_byte),
        .packet_length (packet_length)
    );

endmodule
